@@ src/plvfl_pkg.sv @@
// Package for the pump load/voltage fault lockout block.
// Holds field widths, register indexes, reset values and phase/command codes.
// No dependencies.
package plvfl_pkg;

    // Default width of the wrapping millisecond time base
    localparam int TIME_BITS_DEF = 32;

    // Field widths
    localparam int CUR_W   = 14;
    localparam int VOLT_W  = 13;
    localparam int STAMP_W = 32;
    localparam int TIME_W  = 32;
    localparam int CODE_W  = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_OVERLOAD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNDERLOAD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNDERVOLT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OVERVOLT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT   = 3'd6;

    // Register reset values
    localparam logic [CUR_W-1:0]  OVERLOAD_RST  = 14'd650;
    localparam logic [CUR_W-1:0]  UNDERLOAD_RST = 14'd50;
    localparam logic [VOLT_W-1:0] UNDERVOLT_RST = 13'd1800;
    localparam logic [VOLT_W-1:0] OVERVOLT_RST  = 13'd2600;
    localparam logic [TIME_W-1:0] CONFIRM_RST   = 32'd3000;
    localparam logic [TIME_W-1:0] RETRY_RST     = 32'd3000;
    localparam logic [TIME_W-1:0] LOCKOUT_RST   = 32'd1800000;

    // Protection phases
    localparam logic [CODE_W-1:0] PH_NORMAL  = 2'd0;
    localparam logic [CODE_W-1:0] PH_CONFIRM = 2'd1;
    localparam logic [CODE_W-1:0] PH_LOCKED  = 2'd2;
    localparam logic [CODE_W-1:0] PH_RETRY   = 2'd3;

    // Motor commands
    localparam logic [CODE_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] CMD_STOP  = 2'd1;
    localparam logic [CODE_W-1:0] CMD_START = 2'd2;

    // Fault indication
    localparam logic [CODE_W-1:0] LED_NONE = 2'd0;
    localparam logic [CODE_W-1:0] LED_LOAD = 2'd1;
    localparam logic [CODE_W-1:0] LED_VOLT = 2'd2;

    // Stream payload widths
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 8;

endpackage

@@ src/pump_load_voltage_fault_lockout.sv @@
// Pump motor protection relay: load/voltage fault detection with timed lockout
// and automatic restart. Single module; depends on plvfl_pkg.
//
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata) carries one sensor sample per
//   transaction. Output stream (m_tvalid/m_tready/m_tdata) returns exactly one
//   result per sample, in order: motor command, fault indication, phase.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes one
//   limit or time register per transaction; cfg_ready is always high.
//   Write configuration only while no sample is in flight.
// Flow: an accepted sample waits in the input register and moves into the
//   result register when that is free, which then offers its result.
// Throughput: one sample per cycle while m_tready keeps the output moving; the
//   only work is four limit compares, one subtraction of TIME_BITS bits and
//   three time compares, all between the input and result registers.
// Reset: registers return to their default limits, phase goes to normal, the
//   phase start time clears and both pipeline registers empty.
// Stall: when m_tready is low the result holds; the input register can still
//   take one more sample, after which s_tready drops until the output moves.
module pump_load_voltage_fault_lockout
    import plvfl_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Samples in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [13:0] current_sample, [26:14] voltage_sample, [27] motor_running,
    // [28] mode_enabled, [60:29] time_stamp, [63:61] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Results out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] motor_command, [3:2] fault_indication, [5:4] protect_state, [7:6] zero
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int EXT_W = (TIME_BITS > STAMP_W) ? TIME_BITS : STAMP_W;

    // Configuration registers
    logic [CUR_W-1:0]  overload_reg;
    logic [CUR_W-1:0]  underload_reg;
    logic [VOLT_W-1:0] undervolt_reg;
    logic [VOLT_W-1:0] overvolt_reg;
    logic [TIME_W-1:0] confirm_reg;
    logic [TIME_W-1:0] retry_reg;
    logic [TIME_W-1:0] lockout_reg;

    // Pipeline registers
    logic                 in_valid_reg;
    logic [IN_DATA_W-1:0] in_data_reg;
    logic                 out_valid_reg;
    logic [CODE_W-1:0]    cmd_reg;
    logic [CODE_W-1:0]    led_reg;
    logic [CODE_W-1:0]    state_reg;

    // Protection state
    logic [CODE_W-1:0]    phase_reg;
    logic [CODE_W-1:0]    phase_next;
    logic [TIME_BITS-1:0] start_reg;
    logic [TIME_BITS-1:0] start_next;
    logic [CODE_W-1:0]    cmd_next;
    logic [CODE_W-1:0]    led_next;

    // Unpacked sample fields
    logic [CUR_W-1:0]     cur;
    logic [VOLT_W-1:0]    volt;
    logic                 running;
    logic                 mode_on;
    logic [STAMP_W-1:0]   stamp;
    logic [EXT_W-1:0]     stamp_ext;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] elapsed;
    logic [EXT_W-1:0]     elapsed_ext;
    logic                 load_fault;
    logic                 volt_fault;
    logic                 fault;
    logic                 done_confirm;
    logic                 done_retry;
    logic                 done_lockout;

    logic advance;
    logic out_free;

    assign cfg_ready = 1'b1;

    // Handshake: output register frees when empty or taken
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, state_reg, led_reg, cmd_reg};

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overload_reg  <= OVERLOAD_RST;
            underload_reg <= UNDERLOAD_RST;
            undervolt_reg <= UNDERVOLT_RST;
            overvolt_reg  <= OVERVOLT_RST;
            confirm_reg   <= CONFIRM_RST;
            retry_reg     <= RETRY_RST;
            lockout_reg   <= LOCKOUT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_OVERLOAD:  overload_reg  <= cfg_data[CUR_W-1:0];
                REG_UNDERLOAD: underload_reg <= cfg_data[CUR_W-1:0];
                REG_UNDERVOLT: undervolt_reg <= cfg_data[VOLT_W-1:0];
                REG_OVERVOLT:  overvolt_reg  <= cfg_data[VOLT_W-1:0];
                REG_CONFIRM:   confirm_reg   <= cfg_data[TIME_W-1:0];
                REG_RETRY:     retry_reg     <= cfg_data[TIME_W-1:0];
                REG_LOCKOUT:   lockout_reg   <= cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the incoming sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
        end
    end

    // Unpack fields and classify faults
    assign cur     = in_data_reg[13:0];
    assign volt    = in_data_reg[26:14];
    assign running = in_data_reg[27];
    assign mode_on = in_data_reg[28];
    assign stamp   = in_data_reg[60:29];

    assign stamp_ext   = EXT_W'(stamp);
    assign now         = stamp_ext[TIME_BITS-1:0];
    assign elapsed     = now - start_reg;
    assign elapsed_ext = EXT_W'(elapsed);

    assign done_confirm = elapsed_ext >= EXT_W'(confirm_reg);
    assign done_retry   = elapsed_ext >= EXT_W'(retry_reg);
    assign done_lockout = elapsed_ext >= EXT_W'(lockout_reg);

    assign load_fault = (cur > overload_reg) || (cur < underload_reg);
    assign volt_fault = (volt < undervolt_reg) || (volt > overvolt_reg);
    assign fault      = load_fault || volt_fault;
    assign led_next   = volt_fault ? LED_VOLT : (load_fault ? LED_LOAD : LED_NONE);

    // Next phase and motor command
    always_comb
    begin
        phase_next = phase_reg;
        start_next = start_reg;
        cmd_next   = CMD_NONE;
        case (phase_reg)
            PH_NORMAL:
            begin
                if (fault && running)
                begin
                    phase_next = PH_CONFIRM;
                    start_next = now;
                end
            end
            PH_CONFIRM:
            begin
                if (!fault)
                begin
                    phase_next = PH_NORMAL;
                end
                else if (done_confirm)
                begin
                    cmd_next   = running ? CMD_STOP : CMD_NONE;
                    phase_next = PH_LOCKED;
                    start_next = now;
                end
            end
            PH_LOCKED:
            begin
                if (done_lockout && mode_on)
                begin
                    cmd_next   = running ? CMD_NONE : CMD_START;
                    phase_next = PH_RETRY;
                    start_next = now;
                end
            end
            default:
            begin
                if (done_retry)
                begin
                    if (fault)
                    begin
                        cmd_next   = running ? CMD_STOP : CMD_NONE;
                        phase_next = PH_LOCKED;
                        start_next = now;
                    end
                    else
                    begin
                        phase_next = PH_NORMAL;
                    end
                end
            end
        endcase
    end

    // Advance protection state once per sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NORMAL;
            start_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            start_reg <= start_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd_reg   <= cmd_next;
            led_reg   <= led_next;
            state_reg <= phase_next;
        end
    end

`ifndef SYNTHESIS
    // Normal phase can only move on to confirming
    a_normal_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == PH_NORMAL)
        |=> (phase_reg == PH_NORMAL || phase_reg == PH_CONFIRM))
        else $error("normal phase left for a state other than confirm");

    // A start command only comes with entry into retry run
    a_start_retry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cmd_reg == CMD_START) |-> (state_reg == PH_RETRY))
        else $error("start command outside retry run");

    // A stop command only comes with entry into lockout
    a_stop_locked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cmd_reg == CMD_STOP) |-> (state_reg == PH_LOCKED))
        else $error("stop command outside lockout");

    // A full pipeline with a stalled output takes no new sample
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline full and stalled");

    // The result phase mirrors the state register once it has advanced
    a_state_track: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (state_reg == phase_reg))
        else $error("reported phase differs from internal phase");
`endif

endmodule
